/* sv/ozo_pkg.sv */
`timescale 1ns / 1ps
// Package for the orientation zero-offset block: angle widths, command codes,
// turn constants and the half-turn wrap function. Depends on nothing.
package ozo_pkg;

    localparam int ANGLE_W     = 14;   // one angle in 1/16 degree
    localparam int PITCH_OUT_W = 15;   // pitch difference
    localparam int WIDE_W      = 16;   // differences and averages before the wrap
    localparam int CMD_W       = 2;

    localparam logic [CMD_W-1:0] CMD_READ    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CAPTURE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;

    localparam int HALF_TURN  = 2880;
    localparam int FULL_TURN  = 5760;
    // A 16 bit value lies within six full turns of the +/- half-turn window.
    localparam int WRAP_STEPS = 6;

    typedef logic signed [ANGLE_W-1:0]     angle_t;
    typedef logic signed [WIDE_W-1:0]      wide_t;
    typedef logic signed [PITCH_OUT_W-1:0] pitch_diff_t;
    typedef logic [CMD_W-1:0]              cmd_t;

    typedef struct packed {
        cmd_t   command;
        angle_t heading;
        angle_t roll;
        angle_t pitch;
    } sample_t;

    // Brings a value into [-2880, 2880]. Values above the window come down into
    // (-2880, 2880], values below it come up into [-2880, 2880), so both edges
    // of the window stay as they are. Every candidate is checked in parallel.
    function automatic angle_t wrap_half(input wide_t a);
        int x;
        int c;
        int res;
        x   = int'(a);
        res = x;
        for (int k = 1; k <= WRAP_STEPS; k++)
        begin
            c = x - k * FULL_TURN;
            if (x > HALF_TURN && c <= HALF_TURN && c > -HALF_TURN)
            begin
                res = c;
            end
            c = x + k * FULL_TURN;
            if (x < -HALF_TURN && c >= -HALF_TURN && c < HALF_TURN)
            begin
                res = c;
            end
        end
        return ANGLE_W'(res);
    endfunction

endpackage

/* sv/ozo_in_if.sv */
`timescale 1ns / 1ps
// Sample request channel: valid/ready handshake with one Euler sample and a command.
// Depends on ozo_pkg for the field widths.
interface ozo_in_if;
    logic                               valid;
    logic                               ready;
    logic [ozo_pkg::CMD_W-1:0]          command;
    logic signed [ozo_pkg::ANGLE_W-1:0] heading_in;
    logic signed [ozo_pkg::ANGLE_W-1:0] roll_in;
    logic signed [ozo_pkg::ANGLE_W-1:0] pitch_in;

    modport source (output valid, command, heading_in, roll_in, pitch_in, input ready);
    modport sink   (input valid, command, heading_in, roll_in, pitch_in, output ready);
endinterface

/* sv/ozo_out_if.sv */
`timescale 1ns / 1ps
// Result channel: valid/ready handshake carrying relative angles and zero status.
// Depends on ozo_pkg for the field widths.
interface ozo_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [ozo_pkg::ANGLE_W-1:0]     heading_out;
    logic signed [ozo_pkg::ANGLE_W-1:0]     roll_out;
    logic signed [ozo_pkg::PITCH_OUT_W-1:0] pitch_out;
    logic                                   zero_is_valid;
    logic                                   capture_done;

    modport source (output valid, heading_out, roll_out, pitch_out, zero_is_valid,
                    capture_done, input ready);
    modport sink   (input valid, heading_out, roll_out, pitch_out, zero_is_valid,
                    capture_done, output ready);
endinterface

/* sv/ozo_round_avg.sv */
`timescale 1ns / 1ps
// Rounded average of a capture total: floor((total + N/2) / N) by a reciprocal multiply.
// Depends on ozo_pkg for the wide angle type.
module ozo_round_avg #(
    parameter int CAPTURE_COUNT = 32,
    parameter int TOT_W         = 20
) (
    input  logic signed [TOT_W-1:0] total,
    output ozo_pkg::wide_t          avg
);
    import ozo_pkg::*;

    localparam int LOG_N = $clog2(CAPTURE_COUNT);
    // Every total is bounded by N * 2^14 in magnitude; a bias of that size
    // makes the dividend non-negative.
    localparam int BIAS_UNITS = 1 << 14;
    localparam int DIV_W      = 16 + LOG_N;
    localparam int SHIFT      = DIV_W + LOG_N;
    localparam int RECIP_W    = DIV_W + 1;
    localparam int QUOT_W     = 17;
    localparam logic [63:0] BIAS_FULL = 64'(CAPTURE_COUNT / 2)
                                      + 64'(CAPTURE_COUNT) * 64'(BIAS_UNITS);
    localparam logic [63:0] RECIP_FULL = ((64'd1 << SHIFT) + 64'(CAPTURE_COUNT) - 64'd1)
                                       / 64'(CAPTURE_COUNT);

    logic [DIV_W-1:0]         dividend;
    logic [DIV_W+RECIP_W-1:0] product;
    logic [QUOT_W-1:0]        quotient;
    logic [QUOT_W-1:0]        unbiased;

    // The reciprocal is rounded up; with SHIFT = DIV_W + log2(N) the floor of
    // the scaled product is exact for every dividend below 2^DIV_W.
    assign dividend = DIV_W'(total) + BIAS_FULL[DIV_W-1:0];
    assign product  = (DIV_W + RECIP_W)'(dividend) * (DIV_W + RECIP_W)'(RECIP_FULL[RECIP_W-1:0]);
    assign quotient = product[SHIFT +: QUOT_W];
    assign unbiased = quotient - QUOT_W'(BIAS_UNITS);
    assign avg      = unbiased[WIDE_W-1:0];

endmodule

/* sv/orientation_zero_offset.sv */
`timescale 1ns / 1ps
// Top level of the orientation zero-offset block: capture accumulation, averaging
// pipeline and relative-angle output. Depends on ozo_pkg, ozo_in_if, ozo_out_if, ozo_round_avg.
//
//  Port     | Dir | Handshake    | Carries
//  ---------+-----+--------------+--------------------------------------------------
//  samples  | in  | valid/ready  | command, heading_in, roll_in, pitch_in
//  angles   | out | valid/ready  | heading_out, roll_out, pitch_out, zero_is_valid,
//           |     |              | capture_done
//
// Every request gives one result, registered through each stage in turn. A new
// request can be accepted in every cycle unless every stage is full and stalled. The
// three register stages are the capture accumulation, the reciprocal multiply of
// the average, and the offset subtraction with its wrap. Reset clears the capture,
// the zero and all stage valid bits; no clearing pass is needed. Each stage holds
// its item while the one after it is full and stalled, so bubbles are squeezed out
// and a request is still taken while a finished result waits on the output.
module orientation_zero_offset #(
    parameter int CAPTURE_COUNT = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    ozo_in_if.sink    samples,
    ozo_out_if.source angles
);
    import ozo_pkg::*;

    localparam int LOG_N = $clog2(CAPTURE_COUNT);
    localparam int HT_W  = 15 + LOG_N;   // heading and roll totals
    localparam int PT_W  = 14 + LOG_N;   // pitch total
    localparam int CNT_W = $clog2(CAPTURE_COUNT + 1);
    localparam int TERM_W = 15;          // one unwrapped heading or roll term

    // Capture state, updated as each capture or clear request is accepted.
    angle_t                 ref_heading_reg, ref_roll_reg;
    logic signed [HT_W-1:0] heading_total_reg, roll_total_reg;
    logic signed [PT_W-1:0] pitch_total_reg;
    logic [CNT_W-1:0]       samples_taken_reg;

    // The zero in force for results that have left the last stage.
    angle_t offset_heading_reg, offset_roll_reg, offset_pitch_reg;
    logic   offset_valid_reg;

    // Stage one: the request and the totals including it.
    logic                   p1_vld_reg;
    sample_t                p1_item_reg;
    logic                   p1_done_reg;
    logic signed [HT_W-1:0] p1_heading_tot_reg, p1_roll_tot_reg;
    logic signed [PT_W-1:0] p1_pitch_tot_reg;

    // Stage two: the request and the candidate zero.
    logic    p2_vld_reg;
    sample_t p2_item_reg;
    logic    p2_done_reg;
    angle_t  p2_new_heading_reg, p2_new_roll_reg, p2_new_pitch_reg;

    // Output register.
    logic        out_vld_reg;
    angle_t      heading_out_reg, roll_out_reg;
    pitch_diff_t pitch_out_reg;
    logic        applied_out_reg, capture_done_out_reg;

    // Handshake chain.
    logic out_rdy, p2_rdy, p1_rdy;
    logic p2_adv, p1_adv, accept;

    assign out_rdy       = !out_vld_reg || angles.ready;
    assign p2_adv        = p2_vld_reg && out_rdy;
    assign p2_rdy        = !p2_vld_reg || out_rdy;
    assign p1_adv        = p1_vld_reg && p2_rdy;
    assign p1_rdy        = !p1_vld_reg || p2_rdy;
    assign samples.ready = p1_rdy;
    assign accept        = samples.valid && p1_rdy;

    // ---------------------------------------------------------------------
    // Accumulation. The first capture sample becomes the reference, and every
    // sample is unwrapped to within a half turn of it before it is summed.
    // ---------------------------------------------------------------------
    sample_t                in_item;
    logic                   first_sample;
    angle_t                 ref_heading_use, ref_roll_use;
    logic signed [TERM_W-1:0] heading_term, roll_term;
    logic signed [HT_W-1:0] heading_total_next, roll_total_next;
    logic signed [PT_W-1:0] pitch_total_next;
    logic [CNT_W-1:0]       count_inc;
    logic                   capture_done_next;

    assign in_item.command = samples.command;
    assign in_item.heading = samples.heading_in;
    assign in_item.roll    = samples.roll_in;
    assign in_item.pitch   = samples.pitch_in;

    assign first_sample    = samples_taken_reg == '0;
    assign ref_heading_use = first_sample ? in_item.heading : ref_heading_reg;
    assign ref_roll_use    = first_sample ? in_item.roll : ref_roll_reg;

    assign heading_term = TERM_W'(ref_heading_use)
                        + TERM_W'(wrap_half(WIDE_W'(in_item.heading) - WIDE_W'(ref_heading_use)));
    assign roll_term    = TERM_W'(ref_roll_use)
                        + TERM_W'(wrap_half(WIDE_W'(in_item.roll) - WIDE_W'(ref_roll_use)));

    assign heading_total_next = heading_total_reg + HT_W'(heading_term);
    assign roll_total_next    = roll_total_reg + HT_W'(roll_term);
    assign pitch_total_next   = pitch_total_reg + PT_W'(in_item.pitch);
    assign count_inc          = samples_taken_reg + CNT_W'(1);
    assign capture_done_next  = (in_item.command == CMD_CAPTURE)
                             && (count_inc == CNT_W'(CAPTURE_COUNT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_heading_reg   <= '0;
            ref_roll_reg      <= '0;
            heading_total_reg <= '0;
            roll_total_reg    <= '0;
            pitch_total_reg   <= '0;
            samples_taken_reg <= '0;
        end
        else if (accept)
        begin
            case (in_item.command)
                CMD_CLEAR:
                begin
                    ref_heading_reg   <= '0;
                    ref_roll_reg      <= '0;
                    heading_total_reg <= '0;
                    roll_total_reg    <= '0;
                    pitch_total_reg   <= '0;
                    samples_taken_reg <= '0;
                end
                CMD_CAPTURE:
                begin
                    if (capture_done_next)
                    begin
                        ref_heading_reg   <= '0;
                        ref_roll_reg      <= '0;
                        heading_total_reg <= '0;
                        roll_total_reg    <= '0;
                        pitch_total_reg   <= '0;
                        samples_taken_reg <= '0;
                    end
                    else
                    begin
                        ref_heading_reg   <= ref_heading_use;
                        ref_roll_reg      <= ref_roll_use;
                        heading_total_reg <= heading_total_next;
                        roll_total_reg    <= roll_total_next;
                        pitch_total_reg   <= pitch_total_next;
                        samples_taken_reg <= count_inc;
                    end
                end
                default:
                begin
                    // Reads, including the unused code, leave the capture alone.
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_vld_reg <= 1'b0;
        end
        else if (accept)
        begin
            p1_vld_reg <= 1'b1;
        end
        else if (p1_adv)
        begin
            p1_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_item_reg        <= in_item;
            p1_done_reg        <= capture_done_next;
            p1_heading_tot_reg <= heading_total_next;
            p1_roll_tot_reg    <= roll_total_next;
            p1_pitch_tot_reg   <= pitch_total_next;
        end
    end

    // ---------------------------------------------------------------------
    // Averaging. Only a completing capture uses the result, but the divide
    // runs on every item so the stage has no control of its own.
    // ---------------------------------------------------------------------
    wide_t avg_heading, avg_roll, avg_pitch;

    ozo_round_avg #(
        .CAPTURE_COUNT (CAPTURE_COUNT),
        .TOT_W         (HT_W)
    ) u_avg_heading (
        .total (p1_heading_tot_reg),
        .avg   (avg_heading)
    );

    ozo_round_avg #(
        .CAPTURE_COUNT (CAPTURE_COUNT),
        .TOT_W         (HT_W)
    ) u_avg_roll (
        .total (p1_roll_tot_reg),
        .avg   (avg_roll)
    );

    ozo_round_avg #(
        .CAPTURE_COUNT (CAPTURE_COUNT),
        .TOT_W         (PT_W)
    ) u_avg_pitch (
        .total (p1_pitch_tot_reg),
        .avg   (avg_pitch)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p2_vld_reg <= 1'b0;
        end
        else if (p1_adv)
        begin
            p2_vld_reg <= 1'b1;
        end
        else if (p2_adv)
        begin
            p2_vld_reg <= 1'b0;
        end
    end

    // The pitch average of 14 bit samples always fits 14 bits.
    always_ff @(posedge clk)
    begin
        if (p1_adv)
        begin
            p2_item_reg        <= p1_item_reg;
            p2_done_reg        <= p1_done_reg;
            p2_new_heading_reg <= wrap_half(avg_heading);
            p2_new_roll_reg    <= wrap_half(avg_roll);
            p2_new_pitch_reg   <= avg_pitch[ANGLE_W-1:0];
        end
    end

    // ---------------------------------------------------------------------
    // Output. The zero in force for this item is the stored one, unless the
    // item itself clears it or completes a new one.
    // ---------------------------------------------------------------------
    logic        eff_valid;
    angle_t      eff_heading, eff_roll, eff_pitch;
    angle_t      heading_rel, roll_rel;
    pitch_diff_t pitch_rel;
    logic        p2_is_clear;

    assign p2_is_clear = p2_item_reg.command == CMD_CLEAR;
    assign eff_valid   = p2_is_clear ? 1'b0 : (p2_done_reg ? 1'b1 : offset_valid_reg);
    assign eff_heading = p2_done_reg ? p2_new_heading_reg : offset_heading_reg;
    assign eff_roll    = p2_done_reg ? p2_new_roll_reg : offset_roll_reg;
    assign eff_pitch   = p2_done_reg ? p2_new_pitch_reg : offset_pitch_reg;

    assign heading_rel = eff_valid
                       ? wrap_half(WIDE_W'(p2_item_reg.heading) - WIDE_W'(eff_heading))
                       : p2_item_reg.heading;
    assign roll_rel    = eff_valid
                       ? wrap_half(WIDE_W'(p2_item_reg.roll) - WIDE_W'(eff_roll))
                       : p2_item_reg.roll;
    assign pitch_rel   = eff_valid
                       ? PITCH_OUT_W'(p2_item_reg.pitch) - PITCH_OUT_W'(eff_pitch)
                       : PITCH_OUT_W'(p2_item_reg.pitch);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_heading_reg <= '0;
            offset_roll_reg    <= '0;
            offset_pitch_reg   <= '0;
            offset_valid_reg   <= 1'b0;
        end
        else if (p2_adv)
        begin
            if (p2_is_clear)
            begin
                offset_heading_reg <= '0;
                offset_roll_reg    <= '0;
                offset_pitch_reg   <= '0;
                offset_valid_reg   <= 1'b0;
            end
            else if (p2_done_reg)
            begin
                offset_heading_reg <= p2_new_heading_reg;
                offset_roll_reg    <= p2_new_roll_reg;
                offset_pitch_reg   <= p2_new_pitch_reg;
                offset_valid_reg   <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (p2_adv)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (angles.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p2_adv)
        begin
            heading_out_reg      <= heading_rel;
            roll_out_reg         <= roll_rel;
            pitch_out_reg        <= pitch_rel;
            applied_out_reg      <= eff_valid;
            capture_done_out_reg <= p2_done_reg;
        end
    end

    assign angles.valid         = out_vld_reg;
    assign angles.heading_out   = heading_out_reg;
    assign angles.roll_out      = roll_out_reg;
    assign angles.pitch_out     = pitch_out_reg;
    assign angles.zero_is_valid = applied_out_reg;
    assign angles.capture_done  = capture_done_out_reg;

    // ---------------------------------------------------------------------
    // Assertions.
    // ---------------------------------------------------------------------

    // The capture count wraps to zero on the completing sample.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        samples_taken_reg < CNT_W'(CAPTURE_COUNT))
        else $error("capture count reached the sample limit");

    // A result that completes a capture always applies the new zero.
    a_done_has_zero: assert property (@(posedge clk) disable iff (!rst_n)
        angles.valid && angles.capture_done |-> angles.zero_is_valid)
        else $error("capture completed without a valid zero");

    // A clear leaving the last stage drops the stored zero.
    a_clear_drops_zero: assert property (@(posedge clk) disable iff (!rst_n)
        p2_adv && p2_is_clear |=> !offset_valid_reg)
        else $error("zero still valid after a clear");

    // Relative heading is inside the half-turn window whenever a zero is applied.
    a_heading_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
        angles.valid && angles.zero_is_valid
        |-> (angles.heading_out <= ANGLE_W'(HALF_TURN))
            && (angles.heading_out >= -ANGLE_W'(HALF_TURN)))
        else $error("relative heading outside the half-turn window");

endmodule
